// ----- sv/hamc_pkg.sv -----
// Shared types, constants and elaboration-time helpers for the Hamming codec.
package hamc_pkg;

   localparam int WORD_W = 63;   // width of data and codeword fields
   localparam int SYND_W = 6;    // syndrome / error position width
   localparam int CFG_W  = 6;    // width of each length register

   typedef enum logic [1:0] {
      ST_ENCODED  = 2'd0,
      ST_NO_ERROR = 2'd1,
      ST_CORRECTED = 2'd2,
      ST_BEYOND   = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_DATA_BITS = 1'b0,
      CSR_CODE_BITS = 1'b1
   } csr_index_type;

   function automatic logic is_pow2(input int p);
      return (p != 0) && ((p & (p - 1)) == 0);
   endfunction

   // number of data positions (non power of two) up to and including maxc
   function automatic int max_data(input int maxc);
      int c;
      c = 0;
      for (int p = 1; p <= maxc; p++) begin
         if (!is_pow2(p)) c++;
      end
      return c;
   endfunction

   // data bit index carried at one-based position p (p not a power of two)
   function automatic int data_idx(input int p);
      return max_data(p) - 1;
   endfunction

   // one-based code position of data bit j
   function automatic int data_pos(input int j);
      int c;
      c = 0;
      for (int p = 1; p <= WORD_W; p++) begin
         if (!is_pow2(p)) begin
            if (c == j) return p;
            c++;
         end
      end
      return 0;
   endfunction

   // positions within maxc whose one-based index has bit b set
   function automatic logic [WORD_W-1:0] synd_mask(input int b, input int maxc);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (i < maxc && (((i + 1) >> b) & 1) == 1) m[i] = 1'b1;
      end
      return m;
   endfunction

endpackage

// ----- sv/hamc_if.sv -----
// Request and response channel interfaces of the Hamming codec.
interface hamc_req_if;
   import hamc_pkg::*;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [WORD_W-1:0] in_word;

   modport source (output valid, req_type, in_word, input ready);
   modport sink   (input valid, req_type, in_word, output ready);
endinterface

interface hamc_rsp_if;
   import hamc_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] out_word;
   status_type        status;
   logic [SYND_W-1:0] error_position;

   modport source (output valid, out_word, status, error_position, input ready);
   modport sink   (input valid, out_word, status, error_position, output ready);
endinterface

// ----- sv/hamc_syndrome.sv -----
// Syndrome XOR trees and packed-data gather over a masked codeword.
module hamc_syndrome #(
   parameter int MAX_CODE_BITS = 63
) (
   input  logic [hamc_pkg::WORD_W-1:0] word_i,
   output logic [hamc_pkg::SYND_W-1:0] synd_o,
   output logic [hamc_pkg::WORD_W-1:0] data_o
);
   import hamc_pkg::*;

   localparam int MAX_DATA_BITS = max_data(MAX_CODE_BITS);

   for (genvar b = 0; b < SYND_W; b++) begin : g_synd
      localparam logic [WORD_W-1:0] MASK = synd_mask(b, MAX_CODE_BITS);
      assign synd_o[b] = ^(word_i & MASK);
   end

   for (genvar j = 0; j < WORD_W; j++) begin : g_gather
      if (j < MAX_DATA_BITS) begin : g_bit
         localparam int P = data_pos(j);
         assign data_o[j] = word_i[P-1];
      end else begin : g_zero
         assign data_o[j] = 1'b0;
      end
   end

endmodule

// ----- sv/hamming_encode_decode_top.sv -----
// Top level of the pipelined Hamming single-error-correcting codec.
//
// Requests arrive on req_chan (req_type 0 = encode a data word, 1 = decode a
// codeword); one response per request leaves on rsp_chan in request order.
// csr_wr_en/csr_index/csr_wdata set the encode data length (index 0) and the
// decode codeword length (index 1); write them only while no request is in
// flight. Oversized lengths are clipped to what MAX_CODE_BITS allows.
//
// Pipeline: stage 1 masks the word and scatters data bits onto code positions,
// stage 2 forms the syndrome and gathers the data bits, stage 3 picks the
// result into the output register. An accepted request enters stage 1 at the
// accepting edge and moves through stage 2 to the output register (three
// register stages); one request per cycle is taken when the response keeps up.
// When rsp_chan.ready is low the pipeline fills up and holds; req_chan.ready
// drops only once every stage holds a request. Nothing is dropped or repeated.
// Reset empties the pipeline and loads data length 4 and codeword length 7 (each clipped like a write).
module hamming_encode_decode_top #(
   parameter int MAX_CODE_BITS = 63
) (
   input  logic                            clock,
   input  logic                            reset,
   hamc_req_if.sink                        req_chan,
   hamc_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  hamc_pkg::csr_index_type         csr_index,
   input  logic [hamc_pkg::CFG_W-1:0]      csr_wdata
);
   import hamc_pkg::*;

   localparam int MAX_DATA_BITS = max_data(MAX_CODE_BITS);
   localparam logic [CFG_W-1:0] MAX_DATA_C = CFG_W'(MAX_DATA_BITS);
   localparam logic [CFG_W-1:0] MAX_CODE_C = CFG_W'(MAX_CODE_BITS);
   localparam logic [CFG_W-1:0] DATA_RST   = (MAX_DATA_BITS < 4) ? MAX_DATA_C : CFG_W'(4);
   localparam logic [CFG_W-1:0] CODE_RST   = (MAX_CODE_BITS < 7) ? MAX_CODE_C : CFG_W'(7);

   // configuration
   logic [CFG_W-1:0] data_bits_ff, data_bits_in;
   logic [CFG_W-1:0] code_bits_ff, code_bits_in;

   always_comb begin
      data_bits_in = data_bits_ff;
      code_bits_in = code_bits_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DATA_BITS: data_bits_in = (csr_wdata > MAX_DATA_C) ? MAX_DATA_C : csr_wdata;
            CSR_CODE_BITS: code_bits_in = (csr_wdata > MAX_CODE_C) ? MAX_CODE_C : csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff <= DATA_RST;
         code_bits_ff <= CODE_RST;
      end else begin
         data_bits_ff <= data_bits_in;
         code_bits_ff <= code_bits_in;
      end
   end

   // pipeline flow control
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic adv1, adv2, adv3;

   assign adv3 = !v3_ff || rsp_chan.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_chan.ready = adv1;

   assign v1_in = adv1 ? req_chan.valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage 1: scatter (encode) or length mask (decode)
   logic [WORD_W-1:0] scat, cw_mask;
   logic [WORD_W-1:0] w1_ff, w1_in;
   logic              req1_ff;

   for (genvar i = 0; i < WORD_W; i++) begin : g_stage1
      if (i < MAX_CODE_BITS && !is_pow2(i + 1)) begin : g_data
         localparam int J = data_idx(i + 1);
         assign scat[i] = req_chan.in_word[J] & (data_bits_ff > CFG_W'(J));
      end else begin : g_nodata
         assign scat[i] = 1'b0;
      end
      if (i < MAX_CODE_BITS) begin : g_in
         assign cw_mask[i] = req_chan.in_word[i] & (code_bits_ff > CFG_W'(i));
      end else begin : g_out
         assign cw_mask[i] = 1'b0;
      end
   end

   assign w1_in = req_chan.req_type ? cw_mask : scat;

   always_ff @(posedge clock) begin
      if (adv1) begin
         w1_ff   <= w1_in;
         req1_ff <= req_chan.req_type;
      end
   end

   // stage 2: syndrome and data gather
   logic [SYND_W-1:0] synd1;
   logic [WORD_W-1:0] pack1;
   logic [WORD_W-1:0] w2_ff, pack2_ff;
   logic [SYND_W-1:0] synd2_ff;
   logic              req2_ff;

   hamc_syndrome #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_synd (
      .word_i (w1_ff),
      .synd_o (synd1),
      .data_o (pack1)
   );

   always_ff @(posedge clock) begin
      if (adv2) begin
         w2_ff    <= w1_ff;
         pack2_ff <= pack1;
         synd2_ff <= synd1;
         req2_ff  <= req1_ff;
      end
   end

   // stage 3: select result
   logic [WORD_W-1:0] par_word;
   logic [WORD_W-1:0] flip_word;
   logic [WORD_W-1:0] out_word_ff, out_word_in;
   status_type        status_ff, status_in;
   logic [SYND_W-1:0] err_pos_ff, err_pos_in;

   // parity bit b lands at position 2^b and cancels syndrome bit b
   for (genvar i = 0; i < WORD_W; i++) begin : g_par
      if (is_pow2(i + 1)) begin : g_p
         assign par_word[i] = synd2_ff[$clog2(i + 1)];
      end else begin : g_d
         assign par_word[i] = 1'b0;
      end
   end

   assign flip_word = WORD_W'(1) << (synd2_ff - SYND_W'(1));

   always_comb begin
      out_word_in = w2_ff;
      status_in   = ST_BEYOND;
      err_pos_in  = synd2_ff;
      if (!req2_ff) begin
         out_word_in = w2_ff | par_word;
         status_in   = ST_ENCODED;
         err_pos_in  = '0;
      end else if (synd2_ff == '0) begin
         out_word_in = pack2_ff;
         status_in   = ST_NO_ERROR;
      end else if (synd2_ff <= code_bits_ff) begin
         out_word_in = w2_ff ^ flip_word;
         status_in   = ST_CORRECTED;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         out_word_ff <= out_word_in;
         status_ff   <= status_in;
         err_pos_ff  <= err_pos_in;
      end
   end

   assign rsp_chan.valid          = v3_ff;
   assign rsp_chan.out_word       = out_word_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.error_position = err_pos_ff;

   // checks
   a_enc_no_pos: assert property (@(posedge clock) disable iff (reset)
      v3_ff && status_ff == ST_ENCODED |-> err_pos_ff == '0)
      else $error("encode response carries an error position");

   a_clean_no_pos: assert property (@(posedge clock) disable iff (reset)
      v3_ff && status_ff == ST_NO_ERROR |-> err_pos_ff == '0)
      else $error("clean decode carries an error position");

   a_corr_in_len: assert property (@(posedge clock) disable iff (reset)
      v3_ff && status_ff == ST_CORRECTED |-> err_pos_ff != '0 && err_pos_ff <= code_bits_ff)
      else $error("corrected position outside codeword length");

   a_beyond_len: assert property (@(posedge clock) disable iff (reset)
      v3_ff && status_ff == ST_BEYOND |-> err_pos_ff > code_bits_ff)
      else $error("beyond-length flag with syndrome inside codeword");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v1_ff)
      else $error("accepted request not captured in stage 1");

endmodule
